/* design/cwq_pkg.sv */
package cwq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int MAX_WORDS   = 32;

	localparam int IDX_W   = $clog2(QUEUE_DEPTH);
	localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int CNT_W   = $clog2(MAX_WORDS + 1);
	localparam int PWI_W   = $clog2(MAX_WORDS + 2);
	localparam int KW      = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int VADDR_W = $clog2(QUEUE_DEPTH * MAX_WORDS);

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		KIND_PUSH_STATUS = 2'd0,
		KIND_POP_WORD    = 2'd1,
		KIND_POP_EMPTY   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_APPENDED = 2'd0,
		ST_MERGED   = 2'd1,
		ST_FULL     = 2'd2,
		ST_TOO_LONG = 2'd3
	} status_t;

	// One write request to the value store.
	typedef struct packed {
		logic               en;
		logic [VADDR_W-1:0] addr;
		logic [15:0]        data;
	} vwr_t;

	// Word k of the command held in queue slot s.
	function automatic logic [VADDR_W-1:0] value_addr(logic [IDX_W-1:0] s, logic [KW-1:0] k);
		logic [VADDR_W-1:0] base;
		base = VADDR_W'(s) * VADDR_W'(MAX_WORDS);
		return base + VADDR_W'(k);
	endfunction

endpackage

/* design/coalescing_write_command_queue.sv */
// Ring queue of register-write commands with coalescing of single-word writes.
// Input channel (in_valid/in_ready): op selects a push of one command word or a
// pop of the head command. A push item carries addr, mode, merge_ok, value and
// word_last; the word with word_last set closes the command and produces one
// status item. A non-final push word produces no item.
// Output channel (out_valid/out_ready): push status, popped words (one item per
// stored word, out_last on the final one) or an empty report.
// The block handles one input item at a time and drops in_ready while busy.
// A push word that does not close its command passes through S_PUSH back to
// idle, and a closing one through S_PUSH and then S_RESP. A closing single-word
// push with merge_ok set first walks the occupied slots from head to tail
// through one address comparator, one slot per cycle, and goes to S_RESP on a
// hit or to S_PUSH otherwise. A pop passes each word through S_POP_RD, the
// registered read of the value memory, and S_POP_OUT; an empty pop goes to S_RESP.
// Reset clears the head, tail, occupancy and open-push state; the slot tables
// and value memory are not cleared and are only read after being written.
// When the receiver stalls, the output register holds its item and the
// sequencer waits before producing the next one; no item is lost.
module coalescing_write_command_queue
	import cwq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [15:0] addr,
	input  logic [1:0]  mode,
	input  logic        merge_ok,
	input  logic [15:0] value,
	input  logic        word_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [1:0]  status,
	output logic [15:0] out_addr,
	output logic [1:0]  out_mode,
	output logic [5:0]  out_count,
	output logic [15:0] out_value,
	output logic        out_last
);

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_SEARCH  = 6'b000010,
		S_PUSH    = 6'b000100,
		S_POP_RD  = 6'b001000,
		S_POP_OUT = 6'b010000,
		S_RESP    = 6'b100000
	} state_t;

	state_t state_q;

	// Queue bookkeeping.
	logic [IDX_W-1:0] head_q, tail_q;
	logic [OCC_W-1:0] occ_q;
	logic [PWI_W-1:0] pwi_q;
	logic             dropping_q;

	// Sequencer working registers.
	logic [IDX_W-1:0] srch_q;
	logic [IDX_W-1:0] srch_cnt_q;
	logic [KW-1:0]    k_q;
	kind_t            resp_kind_q;
	status_t          resp_status_q;

	// Latched input item.
	logic [15:0] addr_q;
	logic [1:0]  mode_q;
	logic [15:0] value_q;
	logic        last_q;

	// Slot tables.
	logic [15:0]      ent_addr_q  [QUEUE_DEPTH];
	logic [CNT_W-1:0] ent_words_q [QUEUE_DEPTH];
	logic [1:0]       ent_mode_q  [QUEUE_DEPTH];

	// Output register.
	logic        out_valid_q;
	logic [1:0]  kind_q, status_q, out_mode_q;
	logic [15:0] out_addr_q, out_value_q;
	logic [5:0]  out_count_q;
	logic        out_last_q;

	logic             in_acc;
	logic             out_free;
	logic [IDX_W-1:0] rd_idx;
	logic [15:0]      rd_addr_ent;
	logic [CNT_W-1:0] rd_words;
	logic [1:0]       rd_mode;
	logic             hit;
	logic             pwi_first;
	logic             drop_now;
	logic [PWI_W-1:0] pwi_next;
	logic             too_long;
	logic [CNT_W-1:0] pop_n;
	logic             pop_last;
	logic [15:0]      ram_rd_data;
	vwr_t             vwr;

	function automatic logic [IDX_W-1:0] next_slot(logic [IDX_W-1:0] s);
		return (s == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
	endfunction

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// One read port into the slot tables: the search pointer while searching,
	// the head otherwise.
	assign rd_idx      = (state_q == S_SEARCH) ? srch_q : head_q;
	assign rd_addr_ent = ent_addr_q[rd_idx];
	assign rd_words    = ent_words_q[rd_idx];
	assign rd_mode     = ent_mode_q[rd_idx];

	// The shared comparator of the merge search.
	assign hit = (rd_addr_ent == addr_q) && (rd_words == CNT_W'(1));

	// Push word bookkeeping, following the open-push counter.
	assign pwi_first = (pwi_q == '0);
	assign drop_now  = pwi_first ? (occ_q >= OCC_W'(QUEUE_DEPTH)) : dropping_q;
	assign pwi_next  = (pwi_q < PWI_W'(MAX_WORDS)) ? pwi_q + 1'b1 : PWI_W'(MAX_WORDS + 1);
	assign too_long  = (pwi_next > PWI_W'(MAX_WORDS));

	// Word count of the head command, kept within 1 to MAX_WORDS.
	always_comb begin
		if (rd_words == '0) begin
			pop_n = CNT_W'(1);
		end else if (rd_words > CNT_W'(MAX_WORDS)) begin
			pop_n = CNT_W'(MAX_WORDS);
		end else begin
			pop_n = rd_words;
		end
	end
	assign pop_last = ((CNT_W'(k_q) + 1'b1) == pop_n);

	// Value memory write port: appended words and merged overwrites.
	always_comb begin
		vwr.en   = 1'b0;
		vwr.addr = value_addr(tail_q, pwi_q[KW-1:0]);
		vwr.data = value_q;
		if (state_q == S_PUSH) begin
			vwr.en = !drop_now && (pwi_q < PWI_W'(MAX_WORDS));
		end else if (state_q == S_SEARCH) begin
			vwr.en   = hit;
			vwr.addr = value_addr(srch_q, '0);
		end
	end

	cwq_value_ram u_ram (
		.clk     (clk),
		.wr      (vwr),
		.rd_en   (state_q == S_POP_RD),
		.rd_addr (value_addr(head_q, k_q)),
		.rd_data (ram_rd_data)
	);

	// Slot table writes.
	always_ff @(posedge clk) begin
		if (state_q == S_PUSH) begin
			if (pwi_first && !drop_now) begin
				ent_addr_q[tail_q] <= addr_q;
				ent_mode_q[tail_q] <= mode_q;
			end
			if (last_q && !too_long && !drop_now) begin
				ent_words_q[tail_q] <= CNT_W'(pwi_next);
			end
		end else if (state_q == S_SEARCH && hit) begin
			ent_mode_q[srch_q] <= mode_q;
		end
	end

	// Latched input item.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_q  <= addr;
			mode_q  <= mode;
			value_q <= value;
			last_q  <= word_last;
		end
	end

	// Sequencer and queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			head_q        <= '0;
			tail_q        <= '0;
			occ_q         <= '0;
			pwi_q         <= '0;
			dropping_q    <= 1'b0;
			srch_q        <= '0;
			srch_cnt_q    <= '0;
			k_q           <= '0;
			resp_kind_q   <= KIND_PUSH_STATUS;
			resp_status_q <= ST_APPENDED;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (op_t'(op) == OP_POP) begin
							k_q <= '0;
							if (occ_q == '0) begin
								resp_kind_q   <= KIND_POP_EMPTY;
								resp_status_q <= ST_APPENDED;
								state_q       <= S_RESP;
							end else begin
								state_q <= S_POP_RD;
							end
						end else if (pwi_first && word_last && merge_ok && occ_q != '0) begin
							srch_q     <= head_q;
							srch_cnt_q <= '0;
							state_q    <= S_SEARCH;
						end else begin
							state_q <= S_PUSH;
						end
					end
				end
				S_SEARCH: begin
					if (hit) begin
						resp_kind_q   <= KIND_PUSH_STATUS;
						resp_status_q <= ST_MERGED;
						state_q       <= S_RESP;
					end else if ((OCC_W'(srch_cnt_q) + 1'b1) == occ_q) begin
						state_q <= S_PUSH;
					end else begin
						srch_q     <= next_slot(srch_q);
						srch_cnt_q <= srch_cnt_q + 1'b1;
					end
				end
				S_PUSH: begin
					if (last_q) begin
						resp_kind_q <= KIND_PUSH_STATUS;
						if (too_long) begin
							resp_status_q <= ST_TOO_LONG;
						end else if (drop_now) begin
							resp_status_q <= ST_FULL;
						end else begin
							resp_status_q <= ST_APPENDED;
							tail_q        <= next_slot(tail_q);
							occ_q         <= occ_q + 1'b1;
						end
						pwi_q      <= '0;
						dropping_q <= 1'b0;
						state_q    <= S_RESP;
					end else begin
						pwi_q      <= pwi_next;
						dropping_q <= drop_now;
						state_q    <= S_IDLE;
					end
				end
				S_POP_RD: begin
					state_q <= S_POP_OUT;
				end
				S_POP_OUT: begin
					if (out_free) begin
						if (pop_last) begin
							head_q  <= next_slot(head_q);
							occ_q   <= occ_q - 1'b1;
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_POP_RD;
						end
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (state_q == S_POP_OUT) || (state_q == S_RESP);
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == S_POP_OUT) begin
				kind_q      <= KIND_POP_WORD;
				status_q    <= ST_APPENDED;
				out_addr_q  <= rd_addr_ent;
				out_mode_q  <= rd_mode;
				out_count_q <= 6'(pop_n);
				out_value_q <= ram_rd_data;
				out_last_q  <= pop_last;
			end else if (state_q == S_RESP) begin
				kind_q      <= resp_kind_q;
				status_q    <= resp_status_q;
				out_addr_q  <= '0;
				out_mode_q  <= '0;
				out_count_q <= '0;
				out_value_q <= '0;
				out_last_q  <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign status    = status_q;
	assign out_addr  = out_addr_q;
	assign out_mode  = out_mode_q;
	assign out_count = out_count_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;

endmodule

/* design/cwq_value_ram.sv */
module cwq_value_ram
	import cwq_pkg::*;
(
	input  logic               clk,
	input  vwr_t               wr,
	input  logic               rd_en,
	input  logic [VADDR_W-1:0] rd_addr,
	output logic [15:0]        rd_data
);

	// Value words of all slots, one row of MAX_WORDS words per slot.
	logic [15:0] mem_q [QUEUE_DEPTH * MAX_WORDS];
	logic [15:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
